/* src/ccdc_pkg.sv */
// ----------------------------------------------------------------------------
// ccdc_pkg
// Types and codes shared by the direction-change chain code encoder.
// ----------------------------------------------------------------------------
package ccdc_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    PHASE_ORIGIN,
    PHASE_SECOND,
    PHASE_INSIDE
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_SINGLE    = 2'd1,
    FAULT_NEIGHBOUR = 2'd2,
    FAULT_REVERSAL  = 2'd3
  } fault_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] TURN_STRAIGHT = 2'd0;
  localparam logic [1:0] TURN_RIGHT    = 2'd1;
  localparam logic [1:0] TURN_BACK     = 2'd2;
  localparam logic [1:0] TURN_LEFT     = 2'd3;

  localparam logic [1:0] SYM_LEFT = 2'd2;
  localparam logic [1:0] SYM_END  = 2'd3;

  typedef struct packed {
    logic [1:0] symbol;
    fault_t     fault;
    logic       last_of_run;
  } res_t;

  // Results of one point: none, one, or two.
  typedef struct packed {
    logic any;
    logic two;
    res_t r0;
    res_t r1;
  } pair_t;

endpackage

/* src/ccdc_if.sv */
// ----------------------------------------------------------------------------
// ccdc_if
// Valid/ready channels for curve points and for encoded symbols.
// ----------------------------------------------------------------------------
interface ccdc_pt_if #(
  parameter int COORD_BITS = ccdc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic                         starts_curve;
  logic                         ends_curve;

  modport source (output valid, pos_x, pos_y, starts_curve, ends_curve, input ready);
  modport sink   (input valid, pos_x, pos_y, starts_curve, ends_curve, output ready);
endinterface

interface ccdc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic [1:0] fault;
  logic       last_of_run;

  modport source (output valid, symbol, fault, last_of_run, input ready);
  modport sink   (input valid, symbol, fault, last_of_run, output ready);
endinterface

/* src/chain_code_direction_change_encoder.sv */
// ----------------------------------------------------------------------------
// Path: an accepted point passes the input register, then the result register.
// Throughput: one point per cycle while the output accepts each symbol; a curve's
// final step holds the result register until both its step and end symbols are sent.
// Reset: synchronous, active low; the encoder then awaits a curve origin.
// ----------------------------------------------------------------------------
// chain_code_direction_change_encoder
// Differential 4-connected chain code encoder: input register, step logic,
// result register.
// ----------------------------------------------------------------------------
module chain_code_direction_change_encoder #(
  parameter int COORD_BITS = ccdc_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ccdc_pt_if.sink     in_pts,
  ccdc_res_if.source  out_res
);

  logic                         s1_valid_r;
  logic signed [COORD_BITS-1:0] s1_x_r;
  logic signed [COORD_BITS-1:0] s1_y_r;
  logic                         s1_start_r;
  logic                         s1_end_r;
  logic                         step_go;
  logic                         out_free;
  logic                         in_fire;
  ccdc_pkg::pair_t              pair;

  assign step_go      = s1_valid_r && out_free;
  assign in_pts.ready = !s1_valid_r || step_go;
  assign in_fire      = in_pts.valid && in_pts.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_pts.ready) begin
      s1_valid_r <= in_pts.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r     <= in_pts.pos_x;
      s1_y_r     <= in_pts.pos_y;
      s1_start_r <= in_pts.starts_curve;
      s1_end_r   <= in_pts.ends_curve;
    end
  end

  ccdc_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (step_go),
    .pos_x        (s1_x_r),
    .pos_y        (s1_y_r),
    .starts_curve (s1_start_r),
    .ends_curve   (s1_end_r),
    .pair         (pair)
  );

  ccdc_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (step_go),
    .pair_i  (pair),
    .free    (out_free),
    .out_res (out_res)
  );

endmodule

/* src/ccdc_step.sv */
// ----------------------------------------------------------------------------
// ccdc_step
// Curve state and the per-point decision: step direction, turn and faults.
// ----------------------------------------------------------------------------
module ccdc_step #(
  parameter int COORD_BITS = ccdc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic                         starts_curve,
  input  logic                         ends_curve,
  output ccdc_pkg::pair_t              pair
);

  logic signed [COORD_BITS-1:0] prev_x_r, prev_x_nxt;
  logic signed [COORD_BITS-1:0] prev_y_r, prev_y_nxt;
  logic [1:0]                   prev_dir_r, prev_dir_nxt;
  ccdc_pkg::phase_t             phase_r, phase_nxt;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic                       dx_unit, dy_unit, dx_zero, dy_zero;
  logic [1:0]                 dir;
  logic [1:0]                 turn;
  logic                       open_curve;

  assign dx = {pos_x[COORD_BITS-1], pos_x} - {prev_x_r[COORD_BITS-1], prev_x_r};
  assign dy = {pos_y[COORD_BITS-1], pos_y} - {prev_y_r[COORD_BITS-1], prev_y_r};

  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign dx_unit = (dx == (COORD_BITS+1)'(1)) || (dx == '1);
  assign dy_unit = (dy == (COORD_BITS+1)'(1)) || (dy == '1);

  always_comb begin
    if (dx == (COORD_BITS+1)'(1)) begin
      dir = ccdc_pkg::DIR_RIGHT;
    end else if (dx == '1) begin
      dir = ccdc_pkg::DIR_LEFT;
    end else if (dy == (COORD_BITS+1)'(1)) begin
      dir = ccdc_pkg::DIR_DOWN;
    end else begin
      dir = ccdc_pkg::DIR_UP;
    end
  end

  assign turn = dir - prev_dir_r;
  assign open_curve = (phase_r == ccdc_pkg::PHASE_SECOND) ||
                      (phase_r == ccdc_pkg::PHASE_INSIDE);

  always_comb begin
    prev_x_nxt   = prev_x_r;
    prev_y_nxt   = prev_y_r;
    prev_dir_nxt = prev_dir_r;
    phase_nxt    = phase_r;
    pair.any     = 1'b0;
    pair.two     = 1'b0;
    pair.r0      = '{symbol: 2'd0, fault: ccdc_pkg::FAULT_NONE, last_of_run: 1'b1};
    pair.r1      = '{symbol: ccdc_pkg::SYM_END, fault: ccdc_pkg::FAULT_NONE,
                     last_of_run: 1'b1};

    if (starts_curve) begin
      prev_x_nxt = pos_x;
      prev_y_nxt = pos_y;
      if (ends_curve) begin
        phase_nxt     = ccdc_pkg::PHASE_ORIGIN;
        pair.any      = 1'b1;
        pair.r0.fault = ccdc_pkg::FAULT_SINGLE;
      end else begin
        phase_nxt = ccdc_pkg::PHASE_SECOND;
      end
    end else if (open_curve) begin
      if (!((dx_unit && dy_zero) || (dy_unit && dx_zero))) begin
        phase_nxt     = ccdc_pkg::PHASE_ORIGIN;
        pair.any      = 1'b1;
        pair.r0.fault = ccdc_pkg::FAULT_NEIGHBOUR;
      end else if (phase_r == ccdc_pkg::PHASE_INSIDE && turn == ccdc_pkg::TURN_BACK) begin
        phase_nxt     = ccdc_pkg::PHASE_ORIGIN;
        pair.any      = 1'b1;
        pair.r0.fault = ccdc_pkg::FAULT_REVERSAL;
      end else begin
        prev_x_nxt   = pos_x;
        prev_y_nxt   = pos_y;
        prev_dir_nxt = dir;
        phase_nxt    = ends_curve ? ccdc_pkg::PHASE_ORIGIN : ccdc_pkg::PHASE_INSIDE;
        pair.any     = 1'b1;
        pair.two     = ends_curve;
        pair.r0.last_of_run = !ends_curve;
        if (phase_r == ccdc_pkg::PHASE_SECOND) begin
          pair.r0.symbol = dir;
        end else if (turn == ccdc_pkg::TURN_LEFT) begin
          pair.r0.symbol = ccdc_pkg::SYM_LEFT;
        end else begin
          pair.r0.symbol = turn;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      prev_dir_r <= ccdc_pkg::DIR_UP;
      phase_r    <= ccdc_pkg::PHASE_ORIGIN;
    end else if (go) begin
      prev_x_r   <= prev_x_nxt;
      prev_y_r   <= prev_y_nxt;
      prev_dir_r <= prev_dir_nxt;
      phase_r    <= phase_nxt;
    end
  end

endmodule

/* src/ccdc_out.sv */
// ----------------------------------------------------------------------------
// ccdc_out
// Result register holding up to two symbols of one point, sent one per
// transaction.
// ----------------------------------------------------------------------------
module ccdc_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  ccdc_pkg::pair_t    pair_i,
  output logic               free,
  ccdc_res_if.source         out_res
);

  logic            p_valid_r;
  logic            p_two_r;
  logic            p_idx_r;
  ccdc_pkg::res_t  p_r0_r;
  ccdc_pkg::res_t  p_r1_r;
  ccdc_pkg::res_t  cur;
  logic            fire;
  logic            final_fire;

  assign cur        = p_idx_r ? p_r1_r : p_r0_r;
  assign fire       = p_valid_r && out_res.ready;
  assign final_fire = fire && (!p_two_r || p_idx_r);
  assign free       = !p_valid_r || final_fire;

  assign out_res.valid       = p_valid_r;
  assign out_res.symbol      = cur.symbol;
  assign out_res.fault       = cur.fault;
  assign out_res.last_of_run = cur.last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      p_two_r   <= 1'b0;
      p_idx_r   <= 1'b0;
    end else if (load) begin
      p_valid_r <= pair_i.any;
      p_two_r   <= pair_i.two;
      p_idx_r   <= 1'b0;
    end else if (final_fire) begin
      p_valid_r <= 1'b0;
      p_idx_r   <= 1'b0;
    end else if (fire) begin
      p_idx_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_r0_r <= pair_i.r0;
      p_r1_r <= pair_i.r1;
    end
  end

  a_idx_two : assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && p_idx_r |-> p_two_r)
    else $error("Second symbol selected for a point with one result.");

  a_fault_alone : assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.fault != ccdc_pkg::FAULT_NONE |-> out_res.last_of_run && !p_two_r)
    else $error("Fault result is not the only result of its point.");

  a_end_follows : assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cur.last_of_run |=> out_res.valid && out_res.symbol == ccdc_pkg::SYM_END)
    else $error("End symbol does not follow the final step of a curve.");

  a_load_free : assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("Result register loaded while still holding symbols.");

endmodule
